>>> hdl/oiq_pkg.sv
// shared types and constants for the ordered id queue
package oiq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic append;
        logic search;
        logic shift;
        logic shrink;
        logic heads_start;
        logic heads;
        logic report;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/oiq_ram.sv
// generic single write port ram with registered read
module oiq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/oiq_ctrl.sv
// sequencing state machine for append, search, compaction and head scan
module oiq_ctrl
    import oiq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_remove,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_SEARCH = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_HEADS  = 6'b010000,
        S_REPORT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_in_remove ? S_SEARCH : S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append      = 1'b1;
                o_cmd.heads_start = 1'b1;
                n_state           = S_HEADS;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_SHIFT;
                end else if (i_stat.scan_end) begin
                    o_cmd.heads_start = 1'b1;
                    n_state           = S_HEADS;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.scan_end) begin
                    o_cmd.shrink      = 1'b1;
                    o_cmd.heads_start = 1'b1;
                    n_state           = S_HEADS;
                end
            end
            S_HEADS: begin
                o_cmd.heads = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> hdl/oiq_datapath.sv
// queue storage, counters, scan pointer and output register
module oiq_datapath
    import oiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((2 + 3 * CNT_W + 3 * (ID_BITS + 1) + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_in_remove,
    input  logic [ID_BITS-1:0] i_in_id,
    input  logic               i_in_class,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [OUT_W-1:0]   o_out_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int ENT_W = ID_BITS + 1;

    // request word
    logic [ID_BITS-1:0] r_req_id;
    logic               r_req_cls;
    t_status            r_status;

    // fill counters
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_fill_a;
    logic [CNT_W-1:0] r_fill_b;

    // scan pointer and read pipeline
    logic [CNT_W-1:0] r_cnt;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic             r_hit_cls;

    // head results
    logic [ID_BITS-1:0] r_head_id;
    logic [ID_BITS-1:0] r_a_id;
    logic               r_a_ok;
    logic [ID_BITS-1:0] r_b_id;
    logic               r_b_ok;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic               full;
    logic               hit;
    logic               issue;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [ENT_W-1:0]   rd_data;
    logic [ID_BITS-1:0] rd_id;
    logic               rd_cls;
    logic               head_ok;

    assign rd_id  = rd_data[ID_BITS-1:0];
    assign rd_cls = rd_data[ID_BITS];
    assign full   = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign hit    = i_cmd.search && r_pend && (rd_id == r_req_id);
    assign issue  = (i_cmd.search || i_cmd.shift || i_cmd.heads) && (r_cnt < r_fill) && !hit;

    // compaction writes the word read from slot j+1 into slot j
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fill[IDX_W-1:0];
        ram_wdata = {r_req_cls, r_req_id};
        if (i_cmd.append) begin
            ram_we = !full;
        end else if (i_cmd.shift && r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_pidx - IDX_W'(1);
            ram_wdata = rd_data;
        end
    end

    oiq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_fill_a <= '0;
            r_fill_b <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_pend <= issue;
            if (i_cmd.load) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end
            if (hit) begin
                r_cnt <= CNT_W'(r_pidx) + CNT_W'(1);
            end
            if (i_cmd.append && !full) begin
                r_fill <= r_fill + CNT_W'(1);
                if (r_req_cls) begin
                    r_fill_b <= r_fill_b + CNT_W'(1);
                end else begin
                    r_fill_a <= r_fill_a + CNT_W'(1);
                end
            end
            if (i_cmd.shrink) begin
                r_fill <= r_fill - CNT_W'(1);
                if (r_hit_cls) begin
                    r_fill_b <= r_fill_b - CNT_W'(1);
                end else begin
                    r_fill_a <= r_fill_a - CNT_W'(1);
                end
            end
            if (i_cmd.heads_start) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pidx <= r_cnt[IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_req_id  <= i_in_id;
            r_req_cls <= i_in_class;
            r_status  <= i_in_remove ? ST_NOT_FOUND : ST_DONE;
        end
        if (i_cmd.append && full) begin
            r_status <= ST_FULL;
        end
        if (hit) begin
            r_status  <= ST_DONE;
            r_hit_cls <= rd_cls;
        end
        if (i_cmd.heads && r_pend) begin
            if (r_pidx == '0) begin
                r_head_id <= rd_id;
            end
            if (!rd_cls && !r_a_ok) begin
                r_a_id <= rd_id;
                r_a_ok <= 1'b1;
            end
            if (rd_cls && !r_b_ok) begin
                r_b_id <= rd_id;
                r_b_ok <= 1'b1;
            end
        end
        if (i_cmd.heads_start) begin
            r_a_ok <= 1'b0;
            r_b_ok <= 1'b0;
        end
    end

    assign head_ok = (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.report) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out_data <= OUT_W'({
                r_b_ok,  (r_b_ok  ? r_b_id    : ID_BITS'(0)),
                r_a_ok,  (r_a_ok  ? r_a_id    : ID_BITS'(0)),
                head_ok, (head_ok ? r_head_id : ID_BITS'(0)),
                r_fill_b, r_fill_a, r_fill, r_status
            });
        end
    end

    assign o_stat.hit      = hit;
    assign o_stat.scan_end = (r_cnt >= r_fill) && !r_pend;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

>>> hdl/ordered_id_queue_with_class_heads_unit.sv
// top level of the ordered id queue with per-class heads
//
// usage: one request word in on the s_axis side, one result word out on the
// m_axis side for every request. tuser carries mode (bit 0, 0 append, 1
// remove) and the class (bit 1); tdata carries the id. an append puts the
// id at the tail, a remove deletes the oldest matching id and closes the gap.
// the result gives status, total and per-class counts and the oldest id
// overall and per class, each with its valid flag.
// timing: the request is taken only while the sequencer is idle. an append
// writes the id at the tail, or is refused as full, and then the head scan
// walks the queue before the result word is loaded. a remove first searches,
// and on a hit compacts the words behind the match; search and compaction
// together walk the queue once, then the head scan walks it again, all
// through the single read port of the slot ram, one slot a cycle.
// reset empties the queue at once; slot contents need no clearing pass.
// the result sits in an output register: a stalled receiver holds it there,
// and the next request is still taken and worked on, waiting only before its
// own result word is loaded.
module ordered_id_queue_with_class_heads_unit
    import oiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int IN_W        = ((ID_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((2 + 3 * CNT_W + 3 * (ID_BITS + 1) + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // item_id
    input  logic [1:0]       s_axis_tuser,   // mode, item_class
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, total_count, class_a_count, class_b_count, oldest_id,
    // oldest_valid, oldest_a_id, oldest_a_valid, oldest_b_id, oldest_b_valid
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    oiq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_remove (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    oiq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W),
        .OUT_W       (OUT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_remove (s_axis_tuser[0]),
        .i_in_id     (s_axis_tdata[ID_BITS-1:0]),
        .i_in_class  (s_axis_tuser[1]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
